@@ sv/gbs_pkg.sv @@
// Shared codes and control/status bundles for the graph search block.
package gbs_pkg;

    localparam int INDEX_SPACE = 32;

    localparam logic [1:0] MODE_EDGE = 2'd0;
    localparam logic [1:0] MODE_BFS  = 2'd1;
    localparam logic [1:0] MODE_DFS  = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_VERTEX = 2'd1;
    localparam logic [1:0] ST_FULL       = 2'd2;

    typedef struct packed {
        logic       load_item;
        logic       append_a;
        logic       append_b;
        logic       init_search;
        logic       pop;
        logic       exp_start;
        logic       exp_read;
        logic       exp_check;
        logic       emit;
        logic [1:0] emit_status;
        logic       emit_found;
        logic       emit_last;
        logic       emit_use_cur;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       bad_vertex;
        logic       store_full;
        logic       frontier_empty;
        logic       hit;
        logic       cur_listed;
        logic       at_tail;
        logic       out_free;
    } sts_t;

endpackage

@@ sv/gbs_ctrl.sv @@
// Controller state machine that sequences edge loads and graph searches.
module gbs_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  gbs_pkg::sts_t sts,
    output gbs_pkg::cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_EDGE_A,
        S_EDGE_B,
        S_REPLY,
        S_INIT,
        S_POP,
        S_CHECK,
        S_EXP_RD,
        S_EXP_CHK
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] reply_reg, reply_next;
    logic       first_reg, first_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        reply_next = reply_reg;
        first_next = first_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (sts.mode == gbs_pkg::MODE_NONE)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.bad_vertex)
                begin
                    reply_next = gbs_pkg::ST_BAD_VERTEX;
                    state_next = S_REPLY;
                end
                else if (sts.mode == gbs_pkg::MODE_EDGE)
                begin
                    if (sts.store_full)
                    begin
                        reply_next = gbs_pkg::ST_FULL;
                        state_next = S_REPLY;
                    end
                    else
                    begin
                        state_next = S_EDGE_A;
                    end
                end
                else
                begin
                    state_next = S_INIT;
                end
            end
            S_EDGE_A:
            begin
                cmd.append_a = 1'b1;
                state_next   = S_EDGE_B;
            end
            S_EDGE_B:
            begin
                cmd.append_b = 1'b1;
                reply_next   = gbs_pkg::ST_OK;
                state_next   = S_REPLY;
            end
            S_REPLY:
            begin
                if (sts.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = reply_reg;
                    cmd.emit_last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_INIT:
            begin
                cmd.init_search = 1'b1;
                first_next      = 1'b1;
                state_next      = S_POP;
            end
            S_POP:
            begin
                // The previous vertex goes out only now, once it is known
                // whether another one follows it.
                if (first_reg || sts.out_free)
                begin
                    if (!first_reg)
                    begin
                        cmd.emit         = 1'b1;
                        cmd.emit_use_cur = 1'b1;
                        cmd.emit_status  = gbs_pkg::ST_OK;
                        cmd.emit_last    = sts.frontier_empty;
                    end
                    first_next = 1'b0;
                    if (sts.frontier_empty)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.pop    = 1'b1;
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                priority if (sts.hit)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit         = 1'b1;
                        cmd.emit_use_cur = 1'b1;
                        cmd.emit_status  = gbs_pkg::ST_OK;
                        cmd.emit_found   = 1'b1;
                        cmd.emit_last    = 1'b1;
                        state_next       = S_IDLE;
                    end
                end
                else if (sts.cur_listed)
                begin
                    cmd.exp_start = 1'b1;
                    state_next    = S_EXP_RD;
                end
                else
                begin
                    state_next = S_POP;
                end
            end
            S_EXP_RD:
            begin
                cmd.exp_read = 1'b1;
                state_next   = S_EXP_CHK;
            end
            S_EXP_CHK:
            begin
                cmd.exp_check = 1'b1;
                state_next    = sts.at_tail ? S_POP : S_EXP_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            reply_reg <= gbs_pkg::ST_OK;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            reply_reg <= reply_next;
            first_reg <= first_next;
        end
    end

endmodule

@@ sv/gbs_datapath.sv @@
// Datapath: adjacency store, list heads and tails, frontier, marks and result register.
module gbs_datapath
#(
    parameter int MAX_VERTICES    = 32,
    parameter int MAX_ADJ_ENTRIES = 256
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_write,
    input  logic [5:0]    cfg_data,
    input  logic [1:0]    mode,
    input  logic [4:0]    source_vertex,
    input  logic [4:0]    target_vertex,
    input  logic          out_stall,
    output logic          out_valid,
    output logic [1:0]    status,
    output logic [4:0]    visited_vertex,
    output logic          found,
    output logic          last,
    input  gbs_pkg::cmd_t cmd,
    output gbs_pkg::sts_t sts
);

    localparam int VW      = $clog2(MAX_VERTICES);
    localparam int PW      = $clog2(MAX_VERTICES + 1);
    localparam int AW      = $clog2(MAX_ADJ_ENTRIES);
    localparam int UW      = $clog2(MAX_ADJ_ENTRIES + 1);
    localparam int LIM_CAP = (MAX_VERTICES < gbs_pkg::INDEX_SPACE) ?
                             MAX_VERTICES : gbs_pkg::INDEX_SPACE;

    logic [5:0]    vcount_reg;
    logic [UW-1:0] used_reg;
    logic [MAX_VERTICES-1:0] listed_reg;
    logic [MAX_VERTICES-1:0] visited_reg;
    logic [PW-1:0] rd_reg;
    logic [PW-1:0] wr_reg;
    logic          out_valid_reg;

    logic [AW-1:0] head_reg [MAX_VERTICES];
    logic [AW-1:0] tail_reg [MAX_VERTICES];
    logic [4:0]    front_reg [MAX_VERTICES];
    logic [1:0]    mode_reg;
    logic [4:0]    src_reg;
    logic [4:0]    dst_reg;
    logic [4:0]    cur_reg;
    logic [AW-1:0] e_reg;
    logic [1:0]    status_reg;
    logic [4:0]    vert_out_reg;
    logic          found_reg;
    logic          last_reg;

    logic [4:0]    adj_vert_mem [MAX_ADJ_ENTRIES];
    logic [AW-1:0] adj_next_mem [MAX_ADJ_ENTRIES];
    logic [4:0]    vert_q_reg;
    logic [AW-1:0] next_q_reg;

    logic [6:0]    lim;
    logic [4:0]    owner;
    logic [4:0]    nbr;
    logic          appending;
    logic [VW-1:0] owner_idx;
    logic [VW-1:0] cur_idx;
    logic [VW-1:0] nb_idx;
    logic          nb_take;
    logic [PW-1:0] pop_ptr;

    assign lim = ({1'b0, vcount_reg} > 7'(LIM_CAP)) ? 7'(LIM_CAP) : {1'b0, vcount_reg};

    assign appending = cmd.append_a | cmd.append_b;
    assign owner     = cmd.append_b ? dst_reg : src_reg;
    assign nbr       = cmd.append_b ? src_reg : dst_reg;
    assign owner_idx = VW'(owner);
    assign cur_idx   = VW'(cur_reg);
    assign nb_idx    = VW'(vert_q_reg);
    assign nb_take   = ({2'b00, vert_q_reg} < lim) && !visited_reg[nb_idx];
    assign pop_ptr   = (mode_reg == gbs_pkg::MODE_BFS) ? rd_reg : (wr_reg - PW'(1));

    assign sts.mode           = mode_reg;
    assign sts.bad_vertex     = ({2'b00, src_reg} >= lim) || ({2'b00, dst_reg} >= lim);
    assign sts.store_full     = (used_reg > UW'(MAX_ADJ_ENTRIES - 2));
    assign sts.frontier_empty = (rd_reg == wr_reg);
    assign sts.hit            = (cur_reg == dst_reg);
    assign sts.cur_listed     = listed_reg[cur_idx];
    assign sts.at_tail        = (e_reg == tail_reg[cur_idx]);
    assign sts.out_free       = !out_valid_reg || !out_stall;

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign visited_vertex = vert_out_reg;
    assign found          = found_reg;
    assign last           = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg    <= '0;
            used_reg      <= '0;
            listed_reg    <= '0;
            visited_reg   <= '0;
            rd_reg        <= '0;
            wr_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                vcount_reg <= cfg_data;
            end
            if (appending)
            begin
                used_reg              <= used_reg + UW'(1);
                listed_reg[owner_idx] <= 1'b1;
            end
            if (cmd.init_search)
            begin
                // Only the source is marked when a search starts.
                visited_reg <= MAX_VERTICES'(1) << VW'(src_reg);
                rd_reg      <= '0;
                wr_reg      <= PW'(1);
            end
            if (cmd.pop)
            begin
                if (mode_reg == gbs_pkg::MODE_BFS)
                begin
                    rd_reg <= rd_reg + PW'(1);
                end
                else
                begin
                    wr_reg <= wr_reg - PW'(1);
                end
            end
            if (cmd.exp_check && nb_take)
            begin
                visited_reg[nb_idx] <= 1'b1;
                wr_reg              <= wr_reg + PW'(1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            mode_reg <= mode;
            src_reg  <= source_vertex;
            dst_reg  <= target_vertex;
        end
        if (appending)
        begin
            if (!listed_reg[owner_idx])
            begin
                head_reg[owner_idx] <= AW'(used_reg);
            end
            tail_reg[owner_idx] <= AW'(used_reg);
        end
        if (cmd.init_search)
        begin
            front_reg[0] <= src_reg;
        end
        if (cmd.pop)
        begin
            cur_reg <= front_reg[VW'(pop_ptr)];
        end
        if (cmd.exp_check && nb_take)
        begin
            front_reg[VW'(wr_reg)] <= vert_q_reg;
        end
        if (cmd.exp_start)
        begin
            e_reg <= head_reg[cur_idx];
        end
        else if (cmd.exp_check)
        begin
            e_reg <= next_q_reg;
        end
        if (cmd.emit)
        begin
            status_reg   <= cmd.emit_status;
            vert_out_reg <= cmd.emit_use_cur ? cur_reg : 5'd0;
            found_reg    <= cmd.emit_found;
            last_reg     <= cmd.emit_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (appending)
        begin
            adj_vert_mem[AW'(used_reg)] <= nbr;
        end
        if (cmd.exp_read)
        begin
            vert_q_reg <= adj_vert_mem[e_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (appending && listed_reg[owner_idx])
        begin
            adj_next_mem[tail_reg[owner_idx]] <= AW'(used_reg);
        end
        if (cmd.exp_read)
        begin
            next_q_reg <= adj_next_mem[e_reg];
        end
    end

endmodule

@@ sv/graph_bfs_dfs_search.sv @@
// Graph search top level: edge loading plus breadth-first and depth-first search.
//
// This block builds an undirected graph from edge transfers and searches it. An
// input transfer with mode 0 appends the edge to the adjacency lists of both
// endpoints and answers with one result (status ok, bad vertex, or store full);
// an edge load also waits while the output register is busy. Mode 1 runs a
// breadth-first and mode 2 a depth-first search from source_vertex to
// target_vertex, producing one result per visited vertex, with found set on the
// target and last set on the final result; mode 3 is dropped silently. Each
// adjacency entry is fetched from the adjacency memory with a registered read
// before its neighbor can be marked. The block works on one input transfer at a
// time and raises in_stall until that item is finished; a result waiting in the
// output register does not stop the walk until the next result is ready. The
// vertex_count register sets how many vertices are usable and may only be
// written while the block is idle.
module graph_bfs_dfs_search
#(
    parameter int MAX_VERTICES    = 32,
    parameter int MAX_ADJ_ENTRIES = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [5:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] mode,
    input  logic [4:0] source_vertex,
    input  logic [4:0] target_vertex,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] status,
    output logic [4:0] visited_vertex,
    output logic       found,
    output logic       last
);

    // Command and status bundles between the sequencer and the datapath.
    gbs_pkg::cmd_t cmd;
    gbs_pkg::sts_t sts;

    // The sequencer owns the input handshake and all decisions.
    gbs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the graph, the frontier and the result register.
    gbs_datapath
    #(
        .MAX_VERTICES    (MAX_VERTICES),
        .MAX_ADJ_ENTRIES (MAX_ADJ_ENTRIES)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .mode           (mode),
        .source_vertex  (source_vertex),
        .target_vertex  (target_vertex),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .status         (status),
        .visited_vertex (visited_vertex),
        .found          (found),
        .last           (last),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule

@@ sv/gbs_checker.sv @@
// Port-level checks for the graph search block, bound to the top level.
module gbs_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] status,
    input logic [4:0] visited_vertex,
    input logic       found,
    input logic       last
);

    // A stalled result holds its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) &&
            $stable(visited_vertex) && $stable(found) && $stable(last))
        else $error("stalled result changed");

    // Every accepted item is worked on alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken twice in a row");

    // Error results are single, final and carry no vertex.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != gbs_pkg::ST_OK |->
            last && !found && visited_vertex == 5'd0)
        else $error("malformed error result");

    // Reaching the target ends the search.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> last)
        else $error("found result not final");

endmodule

bind graph_bfs_dfs_search gbs_checker u_gbs_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .visited_vertex (visited_vertex),
    .found          (found),
    .last           (last)
);

@@ dv/tb_top.sv @@
// Self-checking testbench for the graph search block: edge loads, BFS and DFS walks.
`timescale 1ns / 1ps

module tb_top;

    localparam int NV   = 32;
    localparam int NADJ = 256;

    // One result transfer as the block presents it.
    typedef struct packed {
        logic [1:0] status;
        logic [4:0] vertex;
        logic       found;
        logic       last;
    } visit_t;

    // One input transfer; a row of the directed table may carry a typed-in
    // expectation for single-result items (edges and errors).
    typedef struct packed {
        logic [1:0] mode;
        logic [4:0] src;
        logic [4:0] dst;
        logic       has_fixed;
        logic [1:0] fixed_status;
    } request_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_write;
    logic [5:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] mode;
    logic [4:0] source_vertex;
    logic [4:0] target_vertex;
    logic       out_valid;
    logic       out_stall;
    logic [1:0] status;
    logic [4:0] visited_vertex;
    logic       found;
    logic       last;

    graph_bfs_dfs_search u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .source_vertex  (source_vertex),
        .target_vertex  (target_vertex),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .visited_vertex (visited_vertex),
        .found          (found),
        .last           (last)
    );

    // Clock with a 10 ns period.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the graph, kept in step with every accepted transfer.
    int unsigned vcount;
    logic [4:0]  adj_vertex [NADJ];
    int unsigned adj_next   [NADJ];
    int unsigned head       [NV];
    int unsigned tail       [NV];
    bit          listed     [NV];
    int unsigned used_entries;

    visit_t pending_visits [$];
    int     error_count;
    bit     busy_wait;

    // Idling controls, changed from phase to phase; the two rates are in percent.
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    bit          hold_receiver;
    int unsigned hold_cycles;

    // Appends one expected result transfer at the end of the queue.
    function automatic void add_expected(input visit_t r);
        pending_visits.insert(pending_visits.size(), r);
    endfunction

    // Computes the result transfers caused by one request and updates the shadow graph.
    function automatic void predict_walk(input logic [1:0] m, input logic [4:0] s,
                                         input logic [4:0] d);
        int unsigned lim;
        logic [4:0]  frontier [NV];
        bit          marked   [NV];
        int unsigned rd;
        int unsigned wr;
        int unsigned e;
        int unsigned guard;
        int unsigned first;
        logic [4:0]  cur;
        logic [4:0]  nb;
        visit_t      r;
        lim = (vcount > NV) ? NV : vcount;
        if (m == gbs_pkg::MODE_NONE)
            return;
        if (s >= lim || d >= lim)
        begin
            r = '{gbs_pkg::ST_BAD_VERTEX, 5'd0, 1'b0, 1'b1};
            add_expected(r);
            return;
        end
        if (m == gbs_pkg::MODE_EDGE)
        begin
            if (used_entries + 2 > NADJ)
            begin
                r = '{gbs_pkg::ST_FULL, 5'd0, 1'b0, 1'b1};
                add_expected(r);
                return;
            end
            for (int k = 0; k < 2; k++)
            begin
                logic [4:0] owner;
                owner = (k == 0) ? s : d;
                adj_vertex[used_entries] = (k == 0) ? d : s;
                adj_next[used_entries]   = 0;
                if (listed[owner])
                    adj_next[tail[owner]] = used_entries;
                else
                begin
                    head[owner]   = used_entries;
                    listed[owner] = 1'b1;
                end
                tail[owner] = used_entries;
                used_entries++;
            end
            r = '{gbs_pkg::ST_OK, 5'd0, 1'b0, 1'b1};
            add_expected(r);
            return;
        end
        foreach (marked[i])
            marked[i] = 1'b0;
        rd = 0;
        wr = 1;
        frontier[0] = s;
        marked[s] = 1'b1;
        first = pending_visits.size();
        while (rd < wr)
        begin
            if (m == gbs_pkg::MODE_BFS)
            begin
                cur = frontier[rd];
                rd++;
            end
            else
            begin
                wr--;
                cur = frontier[wr];
            end
            r = '{gbs_pkg::ST_OK, cur, cur == d, 1'b0};
            add_expected(r);
            if (cur == d)
                break;
            if (listed[cur])
            begin
                e = head[cur];
                guard = 0;
                forever
                begin
                    if (e >= NADJ || guard >= NADJ)
                        break;
                    nb = adj_vertex[e];
                    if (nb < lim && !marked[nb])
                    begin
                        if (wr < NV)
                        begin
                            frontier[wr] = nb;
                            wr++;
                        end
                        marked[nb] = 1'b1;
                    end
                    if (e == tail[cur])
                        break;
                    e = adj_next[e];
                    guard++;
                end
            end
        end
        if (pending_visits.size() > first)
            pending_visits[$].last = 1'b1;
    endfunction

    // Drives one request and holds it until the block takes it.
    task automatic send_request(input logic [1:0] m, input logic [4:0] s, input logic [4:0] d);
        while (!busy_wait && send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
            @(posedge clk);
        in_valid      <= 1'b1;
        mode          <= m;
        source_vertex <= s;
        target_vertex <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_walk(m, s, d);
        // The block stalls right after a transfer, so this cycle costs nothing.
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Waits until every expected result has arrived, then lets the walk settle.
    task automatic drain_results();
        while (pending_visits.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Register writes happen only here, with the block idle.
    task automatic write_vertex_count(input logic [5:0] value);
        drain_results();
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        vcount = value;
    endtask

    // Result checker: compares each accepted transfer with the oldest expectation.
    always @(posedge clk)
    begin
        visit_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_visits.size() == 0)
            begin
                $error("result transfer with nothing expected: vertex %0d", visited_vertex);
                error_count++;
            end
            else
            begin
                want = pending_visits.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    error_count++;
                end
                if (visited_vertex !== want.vertex)
                begin
                    $error("visited_vertex: expected %0d, got %0d", want.vertex, visited_vertex);
                    error_count++;
                end
                if (found !== want.found)
                begin
                    $error("found: expected %0d, got %0d", want.found, found);
                    error_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, last);
                    error_count++;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off counted here when asked.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_receiver)
        begin
            out_stall <= 1'b1;
            if (hold_cycles == 0)
                hold_receiver <= 1'b0;
            else
                hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    // Directed table: the typed-in status applies to single-result rows only.
    request_t directed [] = '{
        '{gbs_pkg::MODE_EDGE, 5'd0,  5'd0,  1'b1, gbs_pkg::ST_BAD_VERTEX}, // nothing in use
        '{gbs_pkg::MODE_BFS,  5'd0,  5'd0,  1'b1, gbs_pkg::ST_BAD_VERTEX},
        '{gbs_pkg::MODE_NONE, 5'd31, 5'd31, 1'b0, gbs_pkg::ST_OK},  // unused mode
        '{gbs_pkg::MODE_EDGE, 5'd0,  5'd1,  1'b1, gbs_pkg::ST_OK},
        '{gbs_pkg::MODE_EDGE, 5'd1,  5'd2,  1'b1, gbs_pkg::ST_OK},
        '{gbs_pkg::MODE_EDGE, 5'd0,  5'd3,  1'b1, gbs_pkg::ST_OK},
        '{gbs_pkg::MODE_EDGE, 5'd3,  5'd3,  1'b1, gbs_pkg::ST_OK},  // self loop
        '{gbs_pkg::MODE_EDGE, 5'd2,  5'd31, 1'b1, gbs_pkg::ST_OK},
        '{gbs_pkg::MODE_EDGE, 5'd31, 5'd0,  1'b1, gbs_pkg::ST_OK},
        '{gbs_pkg::MODE_EDGE, 5'd31, 5'd30, 1'b1, gbs_pkg::ST_OK},
        '{gbs_pkg::MODE_BFS,  5'd0,  5'd2,  1'b0, gbs_pkg::ST_OK},
        '{gbs_pkg::MODE_DFS,  5'd0,  5'd2,  1'b0, gbs_pkg::ST_OK},
        '{gbs_pkg::MODE_BFS,  5'd0,  5'd0,  1'b0, gbs_pkg::ST_OK},  // source is the target
        '{gbs_pkg::MODE_DFS,  5'd3,  5'd30, 1'b0, gbs_pkg::ST_OK},
        '{gbs_pkg::MODE_BFS,  5'd4,  5'd0,  1'b0, gbs_pkg::ST_OK},  // isolated source
        '{gbs_pkg::MODE_DFS,  5'd5,  5'd6,  1'b0, gbs_pkg::ST_OK},
        '{gbs_pkg::MODE_BFS,  5'd31, 5'd31, 1'b0, gbs_pkg::ST_OK},
        '{gbs_pkg::MODE_NONE, 5'd0,  5'd0,  1'b0, gbs_pkg::ST_OK}
    };

    // Picks a vertex, mostly inside the current limit.
    function automatic logic [4:0] pick_vertex();
        int unsigned lim;
        lim = (vcount > NV) ? NV : vcount;
        if (lim == 0 || $urandom_range(99) < 6)
            return 5'($urandom_range(31));
        return 5'($urandom_range(lim - 1));
    endfunction

    // Random requests: mostly edges and searches over the live vertex range.
    task automatic random_requests(input int count);
        int unsigned pick;
        logic [1:0]  m;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                m = gbs_pkg::MODE_EDGE;
            else if (pick < 70)
                m = gbs_pkg::MODE_BFS;
            else if (pick < 95)
                m = gbs_pkg::MODE_DFS;
            else
                m = gbs_pkg::MODE_NONE;
            send_request(m, pick_vertex(), pick_vertex());
        end
    endtask

    // Main sequence.
    initial
    begin
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        mode           = gbs_pkg::MODE_NONE;
        source_vertex  = '0;
        target_vertex  = '0;
        error_count    = 0;
        busy_wait      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_receiver  = 1'b0;
        hold_cycles    = 0;
        vcount         = 0;
        used_entries   = 0;
        foreach (listed[i])
            listed[i] = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows; the first three run with vertex_count still at reset.
        foreach (directed[i])
        begin
            if (i == 3)
                write_vertex_count(6'd32);
            if (directed[i].has_fixed)
                add_expected('{directed[i].fixed_status, 5'd0, 1'b0, 1'b1});
            send_request(directed[i].mode, directed[i].src, directed[i].dst);
            if (directed[i].has_fixed)
                void'(pending_visits.pop_back());
        end
        // Lowered limit: stored lists stay, high neighbors are skipped.
        write_vertex_count(6'd3);
        send_request(gbs_pkg::MODE_BFS, 5'd0, 5'd2);
        send_request(gbs_pkg::MODE_DFS, 5'd0, 5'd1);
        send_request(gbs_pkg::MODE_EDGE, 5'd0, 5'd3);
        write_vertex_count(6'd63);
        send_request(gbs_pkg::MODE_DFS, 5'd0, 5'd30);

        // Random phases over several register settings and idling mixes.
        write_vertex_count(6'd8);
        random_requests(100);
        send_idle_pct = 56;
        write_vertex_count(6'd32);
        random_requests(100);

        // Long receiver hold-off while the sender keeps offering transfers.
        send_idle_pct  = 0;
        recv_stall_pct = 56;
        hold_cycles    = 300;
        hold_receiver  = 1'b1;
        random_requests(100);
        write_vertex_count(6'd2);
        random_requests(40);

        // Sender pauses until every result is in.
        busy_wait = 1'b1;
        drain_results();
        busy_wait = 1'b0;

        send_idle_pct  = 18;
        recv_stall_pct = 18;
        write_vertex_count(6'd0);
        random_requests(10);
        write_vertex_count(6'd32);
        // Enough edges to fill the adjacency store and hit the full status.
        random_requests(180);

        drain_results();
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("graph_bfs_dfs_search test passed");
        else
            $display("graph_bfs_dfs_search test failed");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #20ms;
        $display("graph_bfs_dfs_search test failed");
        $finish;
    end

endmodule

@@ graph_bfs_dfs_search.f @@
sv/gbs_pkg.sv
sv/gbs_ctrl.sv
sv/gbs_datapath.sv
sv/graph_bfs_dfs_search.sv
sv/gbs_checker.sv
dv/tb_top.sv
